/* hdl/cfip_pkg.sv */
// Shared types and codes for the circular free index pool.
// No dependencies; imported by every module of the block.
package cfip_pkg;

    localparam int POOL_DEPTH_DEF = 1024;
    localparam int IDX_W          = 10;
    localparam int SIZE_W         = 11;
    localparam int STATUS_W       = 3;

    localparam logic [SIZE_W-1:0] POOL_SIZE_RST = 11'd1024;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] STAT_ALLOCATED    = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_EMPTY        = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_FREED        = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_OUT_OF_RANGE = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_FULL         = 3'd4;

    typedef struct packed {
        logic             req_type;
        logic [IDX_W-1:0] value_index;
    } req_item_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [IDX_W-1:0]    alloc_index;
        logic [SIZE_W-1:0]   available_count;
    } res_item_t;

    typedef enum logic {
        CS_IDLE,
        CS_EXEC
    } ctrl_state_t;

    typedef struct packed {
        logic init;  // reinitialize pool from cfg_data
        logic load;  // capture request, issue pool read at head
        logic exec;  // commit request, load result register
    } dp_cmd_t;

endpackage

/* hdl/cfip_ctrl.sv */
// Controller FSM for the circular free index pool: handshakes and sequencing.
// Depends on cfip_pkg.
module cfip_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    output logic             m_valid,
    input  logic             m_ready,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    output cfip_pkg::dp_cmd_t cmd
);
    import cfip_pkg::*;

    ctrl_state_t state_reg, state_next;
    logic        m_valid_reg, m_valid_next;
    logic        out_free;

    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= CS_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            CS_IDLE: begin
                if (s_valid) state_next = CS_EXEC;
            end
            CS_EXEC: begin
                if (out_free) state_next = CS_IDLE;
            end
            default: state_next = CS_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        cmd.init     = cfg_valid;
        cmd.load     = 1'b0;
        cmd.exec     = 1'b0;
        s_ready      = 1'b0;
        m_valid_next = m_valid_reg && !m_ready;
        unique case (state_reg)
            CS_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            CS_EXEC: begin
                // result register must be empty or draining this cycle
                cmd.exec = out_free;
                if (out_free) m_valid_next = 1'b1;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;

endmodule

/* hdl/cfip_dp.sv */
// Datapath for the circular free index pool: pool memory, pointers, counts,
// result register. Depends on cfip_pkg.
module cfip_dp #(
    parameter int POOL_DEPTH = cfip_pkg::POOL_DEPTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  cfip_pkg::dp_cmd_t             cmd,
    input  cfip_pkg::req_item_t           s_data,
    input  logic [cfip_pkg::SIZE_W-1:0]   cfg_data,
    output cfip_pkg::res_item_t           m_data
);
    import cfip_pkg::*;

    localparam int PTR_W   = $clog2(POOL_DEPTH);
    localparam int CNT_W   = $clog2(POOL_DEPTH + 1);
    localparam int RST_EFF = (int'(POOL_SIZE_RST) > POOL_DEPTH) ? POOL_DEPTH
                                                                : int'(POOL_SIZE_RST);

    function automatic logic [CNT_W-1:0] clamp_size(input logic [SIZE_W-1:0] v);
        logic [CNT_W-1:0] r;
        if (v == '0)
            r = CNT_W'(1);
        else if (32'(v) > 32'(POOL_DEPTH))
            r = CNT_W'(POOL_DEPTH);
        else
            r = CNT_W'(v);
        return r;
    endfunction

    logic [IDX_W-1:0]  mem [POOL_DEPTH];
    logic [IDX_W-1:0]  mem_q_reg;
    logic              sel_mem_reg;
    logic              req_reg;
    logic [IDX_W-1:0]  vidx_reg;
    logic [SIZE_W-1:0] pool_size_reg;
    logic [PTR_W-1:0]  head_reg, head_next;
    logic [PTR_W-1:0]  tail_reg, tail_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  fill_reg, fill_next;   // slots written since init
    logic [CNT_W-1:0]  eff_size;
    logic [CNT_W-1:0]  cfg_eff;
    logic              mem_we;
    res_item_t         res;
    res_item_t         out_reg;

    assign eff_size = clamp_size(pool_size_reg);
    assign cfg_eff  = clamp_size(cfg_data);

    // pool store: identity until a slot is written; fill tracks written slots
    always_ff @(posedge aclk) begin
        if (mem_we) mem[tail_next] <= vidx_reg;
        if (cmd.load) begin
            mem_q_reg   <= mem[head_reg];
            sel_mem_reg <= 32'(head_reg) < 32'(fill_reg);
            req_reg     <= s_data.req_type;
            vidx_reg    <= s_data.value_index;
        end
        if (cmd.exec) out_reg <= res;
    end

    always_comb begin
        head_next           = head_reg;
        tail_next           = tail_reg;
        count_next          = count_reg;
        fill_next           = fill_reg;
        mem_we              = 1'b0;
        res.status          = STAT_EMPTY;
        res.alloc_index     = '0;
        if (req_reg == REQ_ALLOC) begin
            if (count_reg != '0) begin
                res.status      = STAT_ALLOCATED;
                res.alloc_index = sel_mem_reg ? mem_q_reg : IDX_W'(head_reg);
                if (32'(head_reg) + 32'd1 >= 32'(eff_size))
                    head_next = '0;
                else
                    head_next = PTR_W'(32'(head_reg) + 32'd1);
                count_next = count_reg - CNT_W'(1);
            end
        end else begin
            if (32'(vidx_reg) >= 32'(eff_size)) begin
                res.status = STAT_OUT_OF_RANGE;
            end else if (count_reg >= eff_size) begin
                res.status = STAT_FULL;
            end else begin
                res.status = STAT_FREED;
                if (32'(tail_reg) + 32'd1 >= 32'(eff_size))
                    tail_next = '0;
                else
                    tail_next = PTR_W'(32'(tail_reg) + 32'd1);
                mem_we     = cmd.exec;
                count_next = count_reg + CNT_W'(1);
                if (fill_reg < eff_size) fill_next = fill_reg + CNT_W'(1);
            end
        end
        res.available_count = SIZE_W'(count_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pool_size_reg <= POOL_SIZE_RST;
            head_reg      <= '0;
            tail_reg      <= PTR_W'(RST_EFF - 1);
            count_reg     <= CNT_W'(RST_EFF);
            fill_reg      <= '0;
        end else if (cmd.init) begin
            pool_size_reg <= cfg_data;
            head_reg      <= '0;
            tail_reg      <= PTR_W'(cfg_eff - CNT_W'(1));
            count_reg     <= cfg_eff;
            fill_reg      <= '0;
        end else if (cmd.exec) begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
            fill_reg  <= fill_next;
        end
    end

    assign m_data = out_reg;

endmodule

/* hdl/circular_free_index_pool.sv */
// Circular free index pool: allocate pops the index at head, free pushes at tail.
// Request and pool read at head are registered in CS_IDLE; CS_EXEC commits
// them to the result register. New requests are taken only in CS_IDLE, after
// the last one's pointer/count update; a waiting result stalls that update.
// Reset (aresetn, synchronous): pool size 1024 clamped to depth, identity pool,
// usable at once; a fill count stands in for a clearing pass.
module circular_free_index_pool #(
    parameter int POOL_DEPTH = cfip_pkg::POOL_DEPTH_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  cfip_pkg::req_item_t         s_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output cfip_pkg::res_item_t         m_data,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [cfip_pkg::SIZE_W-1:0] cfg_data
);
    import cfip_pkg::*;

    dp_cmd_t cmd;

    cfip_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cmd       (cmd)
    );

    cfip_dp #(
        .POOL_DEPTH (POOL_DEPTH)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .s_data   (s_data),
        .cfg_data (cfg_data),
        .m_data   (m_data)
    );

endmodule
